// ----- rtl/ddist_pkg.sv -----
// ----------------------------------------------------------------------------
// ddist_pkg: shared types and constants for the dihedral distance pipeline
// Q30 trig formats, CORDIC arctangent table and inter-module structs.
// ----------------------------------------------------------------------------
package ddist_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_STEPS = 30;
	localparam int RAD_W        = 52;
	localparam int ROOT_W       = RAD_W / 2;
	localparam int DIST_W       = 18;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [31:0] Q30_ONE     = 32'sd1073741824;

	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	typedef struct packed {
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
	} ddist_len_t;

	typedef struct packed {
		logic signed [31:0] ca;
		logic signed [31:0] sa;
		logic signed [31:0] cb;
		logic signed [31:0] sb;
		logic signed [31:0] cd;
	} ddist_trig_t;

	// clamp a 34-bit value to [-1, 1] in Q30
	function automatic logic signed [31:0] sat_q30(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'(Q30_ONE))
			r = Q30_ONE;
		else if (v < -34'(Q30_ONE))
			r = -Q30_ONE;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ----- rtl/ddist_cordic.sv -----
// ----------------------------------------------------------------------------
// ddist_cordic: three-lane pipelined rotation CORDIC
// One step per stage; lengths ride along so they meet the trig results.
// ----------------------------------------------------------------------------
module ddist_cordic (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [15:0]          ang0,
	input  logic [15:0]          ang1,
	input  logic [15:0]          ang2,
	input  ddist_pkg::ddist_len_t  len_in,
	output logic                 out_valid,
	output ddist_pkg::ddist_trig_t trig_out,
	output ddist_pkg::ddist_len_t  len_out
);
	import ddist_pkg::*;

	localparam int N = CORDIC_STEPS;

	logic signed [33:0] x_s [3][N+1];
	logic signed [33:0] y_s [3][N+1];
	logic signed [32:0] z_s [3][N+1];
	logic               flip_s [3][N+1];
	ddist_len_t         len_s [N+1];
	logic [N+1:0]       vld_s;

	logic [15:0] ang [3];
	assign ang[0] = ang0;
	assign ang[1] = ang1;
	assign ang[2] = ang2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s[0] <= len_in;
			for (int k = 0; k < N; k++)
				len_s[k+1] <= len_s[k];
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		logic [31:0] t;
		logic        fl;
		always_comb begin
			t  = {ang[l][ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
			fl = t[31] ^ t[30];
			t[31] = t[31] ^ fl;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[l][0]    <= CORDIC_GAIN;
				y_s[l][0]    <= '0;
				z_s[l][0]    <= {t[31], t};
				flip_s[l][0] <= fl;
			end
		end

		for (genvar i = 0; i < N; i++) begin : g_step
			localparam logic signed [32:0] AT = $signed({1'b0, ATAN_TURNS[i]});
			always_ff @(posedge clk) begin
				if (en) begin
					if (!z_s[l][i][32]) begin
						x_s[l][i+1] <= x_s[l][i] - (y_s[l][i] >>> i);
						y_s[l][i+1] <= y_s[l][i] + (x_s[l][i] >>> i);
						z_s[l][i+1] <= z_s[l][i] - AT;
					end else begin
						x_s[l][i+1] <= x_s[l][i] + (y_s[l][i] >>> i);
						y_s[l][i+1] <= y_s[l][i] - (x_s[l][i] >>> i);
						z_s[l][i+1] <= z_s[l][i] + AT;
					end
					flip_s[l][i+1] <= flip_s[l][i];
				end
			end
		end
	end

	// final stage: undo the half-turn fold and saturate
	logic signed [33:0] xf [3];
	logic signed [33:0] yf [3];
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			xf[l] = flip_s[l][N] ? -x_s[l][N] : x_s[l][N];
			yf[l] = flip_s[l][N] ? -y_s[l][N] : y_s[l][N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trig_out.ca <= sat_q30(xf[0]);
			trig_out.sa <= sat_q30(yf[0]);
			trig_out.cb <= sat_q30(xf[1]);
			trig_out.sb <= sat_q30(yf[1]);
			trig_out.cd <= sat_q30(xf[2]);
			len_out     <= len_s[N];
		end
	end

	assign out_valid = vld_s[N+1];

endmodule

// ----- rtl/ddist_mix.sv -----
// ----------------------------------------------------------------------------
// ddist_mix: product and sum stages forming the radicand
// Five stages, at most one multiply level per stage; clamps negative radicand.
// ----------------------------------------------------------------------------
module ddist_mix (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  ddist_pkg::ddist_trig_t trig,
	input  ddist_pkg::ddist_len_t  len,
	output logic                   out_valid,
	output logic [ddist_pkg::RAD_W-1:0] rad,
	output logic                   clamped
);
	import ddist_pkg::*;

	logic [4:0] vld_s;

	// stage 1
	logic signed [63:0] pcc_s1, pss_s1;
	logic [31:0]        aa_s1, bb_s1, cc_s1, ab_s1, bc_s1, ac_s1;
	logic signed [31:0] ca_s1, cb_s1, cd_s1;
	// stage 2
	logic signed [63:0] pcc_s2, q_s2;
	logic signed [64:0] tab_s2, tbc_s2;
	logic [33:0]        sq_s2;
	logic [31:0]        ac_s2;
	// stage 3
	logic signed [31:0] inner_s3;
	logic signed [50:0] tab_s3, tbc_s3;
	logic [33:0]        sq_s3;
	logic [31:0]        ac_s3;
	// stage 4
	logic signed [64:0] tac_s4;
	logic signed [50:0] tab_s4, tbc_s4;
	logic [33:0]        sq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[3:0], in_valid};
	end

	logic signed [33:0] ssf;
	logic signed [63:0] dif;
	logic signed [33:0] dsh;
	logic signed [53:0] r_sum;
	always_comb begin
		ssf   = 34'(pss_s1 >>> 30);
		dif   = pcc_s2 - q_s2;
		dsh   = 34'(dif >>> 30);
		r_sum = $signed({4'b0, sq_s4, 16'b0})
			+ 54'(2 * (51'(tac_s4 >>> 14) - tab_s4 - tbc_s4));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pcc_s1 <= 64'(trig.ca * trig.cb);
			pss_s1 <= 64'(trig.sa * trig.sb);
			aa_s1  <= len.a * len.a;
			bb_s1  <= len.b * len.b;
			cc_s1  <= len.c * len.c;
			ab_s1  <= len.a * len.b;
			bc_s1  <= len.b * len.c;
			ac_s1  <= len.a * len.c;
			ca_s1  <= trig.ca;
			cb_s1  <= trig.cb;
			cd_s1  <= trig.cd;

			pcc_s2 <= pcc_s1;
			q_s2   <= 64'($signed(ssf[31:0]) * cd_s1);
			tab_s2 <= 65'($signed({1'b0, ab_s1}) * ca_s1);
			tbc_s2 <= 65'($signed({1'b0, bc_s1}) * cb_s1);
			sq_s2  <= 34'(aa_s1) + 34'(bb_s1) + 34'(cc_s1);
			ac_s2  <= ac_s1;

			inner_s3 <= sat_q30(dsh);
			tab_s3   <= 51'(tab_s2 >>> 14);
			tbc_s3   <= 51'(tbc_s2 >>> 14);
			sq_s3    <= sq_s2;
			ac_s3    <= ac_s2;

			tac_s4 <= 65'($signed({1'b0, ac_s3}) * inner_s3);
			tab_s4 <= tab_s3;
			tbc_s4 <= tbc_s3;
			sq_s4  <= sq_s3;

			clamped <= r_sum[53];
			rad     <= r_sum[53] ? '0 : r_sum[RAD_W-1:0];
		end
	end

	assign out_valid = vld_s[4];

endmodule

// ----- rtl/ddist_isqrt.sv -----
// ----------------------------------------------------------------------------
// ddist_isqrt: pipelined integer square root, one root bit per stage
// Output is floor(sqrt(rad)) / 256 as the distance word.
// ----------------------------------------------------------------------------
module ddist_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [ddist_pkg::RAD_W-1:0] rad,
	input  logic                       flag_in,
	output logic                       out_valid,
	output logic [ddist_pkg::DIST_W-1:0] distance,
	output logic                       flag_out
);
	import ddist_pkg::*;

	localparam int N = ROOT_W;

	logic [RAD_W-1:0] v_s   [N+1];
	logic [RAD_W-1:0] res_s [N+1];
	logic             flg_s [N+1];
	logic [N:0]       vld_s;

	assign v_s[0]   = rad;
	assign res_s[0] = '0;
	assign flg_s[0] = flag_in;
	assign vld_s[0] = in_valid;

	for (genvar k = 0; k < N; k++) begin : g_bit
		localparam logic [RAD_W-1:0] BITV = RAD_W'(1) << (2 * (N - 1 - k));
		logic [RAD_W-1:0] trial;
		assign trial = res_s[k] + BITV;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (v_s[k] >= trial) begin
					v_s[k+1]   <= v_s[k] - trial;
					res_s[k+1] <= (res_s[k] >> 1) + BITV;
				end else begin
					v_s[k+1]   <= v_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
				flg_s[k+1] <= flg_s[k];
			end
		end
	end

	assign out_valid = vld_s[N];
	assign distance  = res_s[N][8 +: DIST_W];
	assign flag_out  = flg_s[N];

endmodule

// ----- rtl/dihedral_distance_top.sv -----
// ----------------------------------------------------------------------------
// dihedral_distance_top: end-to-end distance of a four-atom chain
// CORDIC trig, product/sum stages and a bit-per-stage square root.
// ----------------------------------------------------------------------------
//  channel | handshake          | word
//  --------+--------------------+-----------------------------------------
//  in      | in_valid/in_ready  | len_a, len_b, len_c, angle_first,
//          |                    | angle_second, torsion
//  out     | out_valid/out_ready| distance, radicand_clamped
//
// One word enters per cycle while in_ready is high; the pipe runs through
// the CORDIC (fold stage, 30 rotation steps, fix-up), the radicand stages
// and the square root, one root bit per stage.
// Reset clears only the valid bits; data registers are left as they are.
// A stall at the output freezes every stage at once (in_ready drops), so
// no word is lost or repeated; empty slots travel down the pipe as bubbles.
// ----------------------------------------------------------------------------
module dihedral_distance_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] len_a,
	input  logic [15:0] len_b,
	input  logic [15:0] len_c,
	input  logic [15:0] angle_first,
	input  logic [15:0] angle_second,
	input  logic [15:0] torsion,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [17:0] distance,
	output logic        radicand_clamped
);
	import ddist_pkg::*;

	logic        en;
	ddist_len_t  len_in, len_c1;
	ddist_trig_t trig_c1;
	logic        vld_c1, vld_m;
	logic [RAD_W-1:0] rad_m;
	logic        clamp_m;

	// whole pipe advances unless the output word is held
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	assign len_in = '{a: len_a, b: len_b, c: len_c};

	ddist_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.ang0     (angle_first),
		.ang1     (angle_second),
		.ang2     (torsion),
		.len_in   (len_in),
		.out_valid(vld_c1),
		.trig_out (trig_c1),
		.len_out  (len_c1)
	);

	ddist_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_c1),
		.trig     (trig_c1),
		.len      (len_c1),
		.out_valid(vld_m),
		.rad      (rad_m),
		.clamped  (clamp_m)
	);

	ddist_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_m),
		.rad      (rad_m),
		.flag_in  (clamp_m),
		.out_valid(out_valid),
		.distance (distance),
		.flag_out (radicand_clamped)
	);

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for dihedral_distance_top
// Drives chain geometry words under random idling on both sides, predicts each
// distance with a bit-exact fixed-point model and checks results in order.
// ----------------------------------------------------------------------------
module tb;
	import ddist_pkg::*;

	localparam int LATENCY     = 63;
	localparam int CYCLE_LIMIT = 400000;

	// Expected result word.
	typedef struct {
		logic [17:0] dist_val;
		logic        clamped;
	} dist_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] len_a = '0, len_b = '0, len_c = '0;
	logic [15:0] angle_first = '0, angle_second = '0, torsion = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [17:0] distance;
	logic        radicand_clamped;

	dist_word_t expected_dist_q[$];
	int         mismatches = 0;
	int         checked = 0;
	int         clamp_seen = 0;
	int         cycles = 0;
	bit         steady = 1'b0;  // no idling on either side while set

	always #10 clk = ~clk;

	dihedral_distance_top i_dut (.*);

	// ---------------------------------------------------------------- predictor
	function automatic longint floor_shr(longint v, int s);
		return v >>> s;  // arithmetic shift on signed longint is a floor
	endfunction

	function automatic longint clamp_unit(longint v);
		longint one;
		one = longint'(1) << 30;
		if (v > one) return one;
		if (v < -one) return -one;
		return v;
	endfunction

	// Rotation CORDIC on the binary angle; cos/sin in Q30.
	task automatic trig_of(input logic [15:0] ang, output longint cv, output longint sv);
		logic [31:0] t;
		bit          flip;
		longint      x, y, z, nx;
		t = {ang, 16'h0};
		flip = 1'b0;
		if (((t + 32'h4000_0000) & 32'h8000_0000) != 0) begin
			flip = 1'b1;
			t ^= 32'h8000_0000;
		end
		z = longint'($signed(t));
		x = 652032874;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			if (z >= 0) begin
				nx = x - floor_shr(y, i);
				y = y + floor_shr(x, i);
				z -= longint'(ATAN_TURNS[i]);
			end else begin
				nx = x + floor_shr(y, i);
				y = y - floor_shr(x, i);
				z += longint'(ATAN_TURNS[i]);
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		cv = clamp_unit(x);
		sv = clamp_unit(y);
	endtask

	function automatic longint unsigned root_of(longint unsigned v);
		longint unsigned res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > v) bt >>= 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v -= res + bt;
				res = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		return res;
	endfunction

	task automatic predict_distance(input logic [15:0] a16, b16, c16, af, as, tor,
			output dist_word_t w);
		longint          a, b, c, ca, sa, cb, sb, cd, sd, inner, r;
		longint unsigned d;
		a = a16; b = b16; c = c16;
		trig_of(af, ca, sa);
		trig_of(as, cb, sb);
		trig_of(tor, cd, sd);
		inner = clamp_unit(floor_shr(ca * cb - floor_shr(sa * sb, 30) * cd, 30));
		r = ((a * a + b * b + c * c) <<< 16)
			+ 2 * (-floor_shr(a * b * ca, 14) - floor_shr(b * c * cb, 14)
			+ floor_shr(a * c * inner, 14));
		w.clamped = 1'b0;
		if (r < 0) begin
			r = 0;
			w.clamped = 1'b1;
		end
		d = root_of(longint'(r)) >> 8;
		if (d > 262143) d = 262143;
		w.dist_val = d[17:0];
	endtask

	// ---------------------------------------------------------------- drivers
	function automatic bit idle_now();
		return !steady && ($urandom_range(99) < 7);
	endfunction

	// Send one word; valid holds until accepted, gaps only between words.
	task automatic send_word(input logic [15:0] a, b, c, af, as, tor);
		dist_word_t w;
		while (idle_now()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		predict_distance(a, b, c, af, as, tor, w);
		len_a <= a; len_b <= b; len_c <= c;
		angle_first <= af; angle_second <= as; torsion <= tor;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_dist_q.push_back(w);
		@(negedge clk);
	endtask

	// Receiver back-pressure, changed on the falling edge.
	always @(negedge clk) out_ready <= !idle_now();

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("ERROR %s: got %0d expected %0d (result %0d)", what, got, want, checked);
		mismatches++;
	endtask

	// Result checker.
	always @(posedge clk) begin
		dist_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_dist_q.size() == 0) begin
				report_mismatch("unexpected word", distance, -1);
			end else begin
				w = expected_dist_q.pop_front();
				if (distance !== w.dist_val) report_mismatch("distance", distance, w.dist_val);
				if (radicand_clamped !== w.clamped)
					report_mismatch("radicand_clamped", radicand_clamped, w.clamped);
				if (w.clamped) clamp_seen++;
			end
			checked++;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests
	function automatic logic [15:0] rnd_angle();
		// mostly random, sometimes near quadrant edges
		logic [15:0] q;
		if ($urandom_range(9) < 2) begin
			q = 16'($urandom_range(3)) << 14;
			return q + 16'($urandom_range(4)) - 16'd2;
		end
		return 16'($urandom);
	endfunction

	task automatic test_directed();
		logic [15:0] lens[4] = '{16'h0000, 16'h0001, 16'h1000, 16'hFFFF};
		logic [15:0] angs[6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h3FFF};
		for (int i = 0; i < 4; i++)
			send_word(lens[i], lens[i], lens[i], angs[i], angs[5 - i], angs[i + 1]);
		// straight chain, folded chain, zero middle bond
		send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h0000);
		send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
		send_word(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h8000);
		send_word(16'h1000, 16'h1000, 16'h1000, 16'h0000, 16'h0000, 16'h0000);
		// near-degenerate sums where rounding may push the radicand negative
		for (int i = 0; i < 8; i++)
			send_word(16'h1000 + 16'(i), 16'h1000, 16'h1000 - 16'(i),
				16'(i), 16'hFFFF - 16'(i), 16'h8000 + 16'(i));
		send_word(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
		send_word(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
	endtask

	task automatic test_random(input int n);
		logic [15:0] a, b, c;
		for (int i = 0; i < n; i++) begin
			steady = (i >= n / 3) && (i < n / 2);
			a = 16'($urandom); b = 16'($urandom); c = 16'($urandom);
			if ($urandom_range(9) == 0) begin
				// equal lengths: pushes toward cancellation
				b = a; c = a;
			end
			send_word(a, b, c, rnd_angle(), rnd_angle(), rnd_angle());
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(1400);
		in_valid <= 1'b0;
		while (expected_dist_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("checked %0d distance words, %0d with clamped radicand,", checked, clamp_seen);
		$display("under random idling on both sides and one idle-free stretch");
		if (mismatches == 0 && expected_dist_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
